FILE: rtl/wrs_pkg.sv
// ---------------------------------------------------------------------------
// wrs_pkg
// Shared constants for the weighted random selector: field widths,
// operation codes and default sizing.
// ---------------------------------------------------------------------------
`default_nettype none

package wrs_pkg;

   // field widths of the transaction and register ports
   localparam int OP_BITS     = 1;
   localparam int INDEX_BITS  = 4;
   localparam int WVALUE_BITS = 16;
   localparam int RANDOM_BITS = 31;
   localparam int COUNT_BITS  = 5;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_WRITE  = 1'b0;
   localparam logic [OP_BITS-1:0] OP_CHOOSE = 1'b1;

   // default sizing of the weight table
   localparam int DEFAULT_ENTRIES     = 16;
   localparam int DEFAULT_WEIGHT_BITS = 16;

endpackage : wrs_pkg

`default_nettype wire

FILE: rtl/weighted_random_selector.sv
// ---------------------------------------------------------------------------
// weighted_random_selector
// Roulette-wheel selection over a table of per-entry weights held in a
// synchronous memory.
// ---------------------------------------------------------------------------
// Usage
//   A transaction is taken on the rising edge where start is high and busy
//   is low. req_op selects a weight write (entry req_entry_index gets
//   req_weight_value) or a choice driven by req_random_value.
//   A write completes at the accepting edge, gives no result and leaves
//   busy low, so a new transaction may follow in the next cycle.
//   A choice raises busy and runs three phases on the one table read port:
//     sum    - read the active weights and total them
//     reduce - restoring remainder of the random value, one bit a cycle
//     scan   - running sum until it exceeds the roll
//   With a zero total the reduce and scan phases are skipped.
//   How long a choice holds busy is set by the single read port and the
//   bit-serial reduction.
//   The result is shown on rsp_* for exactly one cycle, marked by rsp_valid;
//   the receiver cannot stall it. busy falls as the result appears.
//   csr_wr_en writes entry_count (clamped to ENTRIES on use); write it only
//   while idle.
//   Reset (synchronous) clears entry_count, all table valid bits (entries
//   read as zero until written) and the sequencer; no clearing pass is run.
// ---------------------------------------------------------------------------
`default_nettype none

module weighted_random_selector
   import wrs_pkg::*;
#(
   parameter int ENTRIES     = DEFAULT_ENTRIES,
   parameter int WEIGHT_BITS = DEFAULT_WEIGHT_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // command channel
   input  wire logic                   start,
   output      logic                   busy,
   input  wire logic [OP_BITS-1:0]     req_op,
   input  wire logic [INDEX_BITS-1:0]  req_entry_index,
   input  wire logic [WVALUE_BITS-1:0] req_weight_value,
   input  wire logic [RANDOM_BITS-1:0] req_random_value,
   // result channel
   output      logic                   rsp_valid,
   output      logic [INDEX_BITS-1:0]  rsp_chosen_index,
   output      logic                   rsp_no_choice,
   // register port
   input  wire logic                   csr_wr_en,
   input  wire logic [COUNT_BITS-1:0]  csr_wr_data
);

   // widths derived from the table size
   localparam int ADDR_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ENT_BITS  = $clog2(ENTRIES + 1);
   localparam int CW        = (ENT_BITS > COUNT_BITS) ? ENT_BITS : COUNT_BITS;
   localparam int SUM_BITS  = WEIGHT_BITS + ENT_BITS;
   localparam int STEP_BITS = $clog2(RANDOM_BITS);
   localparam logic [CW-1:0]        ENTRIES_CW = CW'(ENTRIES);
   localparam logic [STEP_BITS-1:0] LAST_STEP  = STEP_BITS'(RANDOM_BITS - 1);

   // sequencer codes
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SUM    = 2'd1;
   localparam logic [1:0] ST_REDUCE = 2'd2;
   localparam logic [1:0] ST_SCAN   = 2'd3;

   // weight table and its valid bits
   logic [WEIGHT_BITS-1:0] table_mem [ENTRIES];
   logic [ENTRIES-1:0]     vld_ff, vld_in;

   // control registers
   logic [1:0]             state_ff, state_in;
   logic [COUNT_BITS-1:0]  csr_count_ff, csr_count_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          issue_ff, issue_in;
   logic                   rd_vld_ff;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [ADDR_BITS-1:0]   rd_idx_ff;
   logic [WEIGHT_BITS-1:0] rd_data_ff;
   logic [SUM_BITS-1:0]    total_ff, total_in;
   logic [SUM_BITS-1:0]    run_ff, run_in;
   logic [SUM_BITS-1:0]    rem_ff, rem_in;
   logic [RANDOM_BITS-1:0] dividend_ff, dividend_in;
   logic [INDEX_BITS-1:0]  rsp_index_ff, rsp_index_in;
   logic                   rsp_none_ff, rsp_none_in;

   // helpers
   logic                   accept;
   logic                   wr_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [WEIGHT_BITS-1:0] wr_data;
   logic                   rd_en;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic [CW-1:0]          req_count;
   logic                   reads_done;
   logic [SUM_BITS:0]      trial;
   logic [SUM_BITS-1:0]    run_next;
   logic [ADDR_BITS+INDEX_BITS-1:0] wr_addr_wide;
   logic [ADDR_BITS+INDEX_BITS-1:0] hit_idx_wide;
   logic [WEIGHT_BITS+WVALUE_BITS-1:0] wr_data_wide;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // write address and data: zero-extend, then keep the table's own width
   assign wr_addr_wide = {{ADDR_BITS{1'b0}}, req_entry_index};
   assign wr_addr      = wr_addr_wide[ADDR_BITS-1:0];
   assign wr_data_wide = {{WEIGHT_BITS{1'b0}}, req_weight_value};
   assign wr_data      = wr_data_wide[WEIGHT_BITS-1:0];
   // writes beyond the table are dropped
   assign wr_en = accept && (req_op == OP_WRITE) && (CW'(req_entry_index) < ENTRIES_CW);

   // one read a cycle while entries remain in the sum and scan phases
   assign rd_en   = ((state_ff == ST_SUM) || (state_ff == ST_SCAN)) && (issue_ff < count_ff);
   assign rd_addr = issue_ff[ADDR_BITS-1:0];
   assign reads_done = (issue_ff == count_ff) && !rd_vld_ff;

   // clamp the programmed count to the table size
   assign req_count = (CW'(csr_count_ff) > ENTRIES_CW) ? ENTRIES_CW : CW'(csr_count_ff);

   // remainder step and running sum
   assign trial    = {rem_ff, dividend_ff[RANDOM_BITS-1]};
   assign run_next = run_ff + SUM_BITS'(rd_data_ff);
   assign hit_idx_wide = {{INDEX_BITS{1'b0}}, rd_idx_ff};

   always_comb begin
      state_in     = state_ff;
      csr_count_in = csr_count_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      step_in      = step_ff;
      vld_in       = vld_ff;
      total_in     = total_ff;
      run_in       = run_ff;
      rem_in       = rem_ff;
      dividend_in  = dividend_ff;
      rsp_valid_in = 1'b0;
      rsp_index_in = rsp_index_ff;
      rsp_none_in  = rsp_none_ff;

      if (csr_wr_en) begin
         csr_count_in = csr_wr_data;
      end
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      if (rd_en) begin
         issue_in = issue_ff + CW'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_CHOOSE)) begin
               state_in    = ST_SUM;
               count_in    = req_count;
               issue_in    = '0;
               total_in    = '0;
               dividend_in = req_random_value;
            end
         end
         ST_SUM: begin
            if (rd_vld_ff) begin
               total_in = total_ff + SUM_BITS'(rd_data_ff);
            end
            if (reads_done) begin
               if (total_ff == '0) begin
                  // nothing to draw from: report no choice at once
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_index_in = '0;
                  rsp_none_in  = 1'b1;
               end else begin
                  state_in = ST_REDUCE;
                  rem_in   = '0;
                  step_in  = '0;
               end
            end
         end
         ST_REDUCE: begin
            // restoring remainder, most significant dividend bit first
            if (trial >= {1'b0, total_ff}) begin
               rem_in = SUM_BITS'(trial - {1'b0, total_ff});
            end else begin
               rem_in = trial[SUM_BITS-1:0];
            end
            dividend_in = {dividend_ff[RANDOM_BITS-2:0], 1'b0};
            step_in     = step_ff + STEP_BITS'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_SCAN;
               issue_in = '0;
               run_in   = '0;
            end
         end
         ST_SCAN: begin
            if (rd_vld_ff) begin
               run_in = run_next;
               if (rem_ff < run_next) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_index_in = hit_idx_wide[INDEX_BITS-1:0];
                  rsp_none_in  = 1'b0;
               end
            end
            if (reads_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               rsp_none_in  = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_addr] ? table_mem[rd_addr] : '0;
         rd_idx_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_count_ff <= '0;
         vld_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_count_ff <= csr_count_in;
         vld_ff       <= vld_in;
         rd_vld_ff    <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff     <= count_in;
      issue_ff     <= issue_in;
      step_ff      <= step_in;
      total_ff     <= total_in;
      run_ff       <= run_in;
      rem_ff       <= rem_in;
      dividend_ff  <= dividend_in;
      rsp_index_ff <= rsp_index_in;
      rsp_none_ff  <= rsp_none_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_index = rsp_index_ff;
   assign rsp_no_choice    = rsp_none_ff;

`ifndef SYNTH
   // a result only follows a busy cycle of the sequencer
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff != ST_IDLE))
      else $error("result strobe without a running choice");

   // an accepted choice keeps the block busy in the next cycle
   a_choose_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_CHOOSE)) |=> busy)
      else $error("choice accepted but block not busy");

   // partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_REDUCE) && (step_ff != '0)) || (state_ff == ST_SCAN)
         |-> (rem_ff < total_ff))
      else $error("remainder out of range");

   // no choice reports index zero
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_choice) |-> (rsp_chosen_index == '0))
      else $error("no-choice result with nonzero index");
`endif

endmodule : weighted_random_selector

`default_nettype wire
